>>> design/rsc_pkg.sv
package rsc_pkg;

  // Sizes
  localparam int unsigned MaxElems = 16;
  localparam int unsigned MaxSegs  = 64;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned SegCntW  = 7;
  localparam int unsigned PendW    = 24;

  // Command codes
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_PRODUCE = 3'd1;
  localparam logic [2:0] CMD_COPY    = 3'd2;
  localparam logic [2:0] CMD_FREE    = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ATTACHED   = 3'd0;
  localparam logic [2:0] REG_SRC_BASE   = 3'd1;
  localparam logic [2:0] REG_SRC_END    = 3'd2;
  localparam logic [2:0] REG_SRC_START  = 3'd3;
  localparam logic [2:0] REG_ELEM_COUNT = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic produce;
    logic free;
    logic start_copy;
    logic step;
    logic query;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic finish;
    logic out_valid;
  } sts_t;

  // Element count clamped to 1..MaxElems
  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (c == '0) r = CountW'(1);
    if (c > CountW'(MaxElems)) r = CountW'(MaxElems);
    return r;
  endfunction

endpackage

>>> design/rsc_ctrl.sv
module rsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        cmd_i,
  input  logic              out_stall_i,
  input  rsc_pkg::sts_t     sts_i,
  output rsc_pkg::ctl_t     ctl_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_COPY, ST_QUERY} state_e;

  state_e state_q;
  logic   accept;
  logic   out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  // output register can take a new result this cycle
  assign out_free   = !sts_i.out_valid || !out_stall_i;

  // command decode
  always_comb begin
    ctl_o            = '0;
    ctl_o.load       = accept && (cmd_i == rsc_pkg::CMD_LOAD);
    ctl_o.produce    = accept && (cmd_i == rsc_pkg::CMD_PRODUCE);
    ctl_o.free       = accept && (cmd_i == rsc_pkg::CMD_FREE);
    ctl_o.start_copy = accept && (cmd_i == rsc_pkg::CMD_COPY);
    ctl_o.step       = (state_q == ST_COPY) && out_free;
    ctl_o.query      = (state_q == ST_QUERY) && out_free;
  end

  // state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && cmd_i == rsc_pkg::CMD_COPY) state_q <= ST_COPY;
          else if (accept && cmd_i == rsc_pkg::CMD_QUERY) state_q <= ST_QUERY;
        end
        ST_COPY: begin
          if (out_free && sts_i.finish) state_q <= ST_IDLE;
        end
        ST_QUERY: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/rsc_dpath.sv
module rsc_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsc_pkg::ctl_t     ctl_i,
  output rsc_pkg::sts_t     sts_o,
  input  logic [3:0]        elem_index_i,
  input  logic [31:0]       elem_dest_i,
  input  logic [15:0]       elem_size_i,
  input  logic [15:0]       byte_count_i,
  input  logic [31:0]       src_write_addr_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [31:0]       seg_src_addr_o,
  output logic              seg_zero_fill_o,
  output logic [31:0]       seg_dst_addr_o,
  output logic [15:0]       seg_len_o,
  output logic              last_o,
  output logic [16:0]       avail_bytes_o,
  output logic              truncated_o
);

  localparam int unsigned IdxW    = rsc_pkg::IdxW;
  localparam int unsigned CountW  = rsc_pkg::CountW;
  localparam int unsigned SegCntW = rsc_pkg::SegCntW;
  localparam int unsigned PendW   = rsc_pkg::PendW;

  // configuration
  logic              attached_q;
  logic [31:0]       base_q, end_q, start_q;
  logic [CountW-1:0] ecount_q;

  // element tables
  logic [31:0] dest_mem [rsc_pkg::MaxElems];
  logic [15:0] size_mem [rsc_pkg::MaxElems];

  // planner state
  logic [31:0]        rp_q;
  logic [PendW-1:0]   pend_q;
  logic [IdxW-1:0]    didx_q;
  logic [15:0]        doff_q;
  logic               live_q;

  // copy in progress
  logic [15:0]        rem_q;
  logic [31:0]        wr_q;
  logic               fill_q;
  logic [CountW-1:0]  emp_q;
  logic [SegCntW-1:0] nseg_q;

  // segment held back until it is known whether it is the last one
  logic        held_valid_q;
  logic [31:0] h_src_q, h_dst_q;
  logic        h_zf_q;
  logic [15:0] h_len_q;

  logic out_valid_q;

  // step terms
  logic [CountW-1:0] cnt;
  logic              idx_ovf;
  logic [IdxW-1:0]   idx, nidx;
  logic [CountW-1:0] idx_inc, emp_inc;
  logic [15:0]       off, size, room, seg, chunk, chunk_s;
  logic [31:0]       run, rsum, rnext, dst;
  logic              fill_now, room0, emp_hit, rem_zero, seg_lim;
  logic              finish, fin_trunc, emit;
  logic [20:0]       prod;
  logic [16:0]       avail;
  logic              cfg_we, out_pop, out_we_step;
  logic [PendW:0]    psum;

  assign cnt     = rsc_pkg::eff_count(ecount_q);
  assign idx_ovf = ({1'b0, didx_q} >= cnt);
  assign idx     = idx_ovf ? '0 : didx_q;
  assign off     = idx_ovf ? '0 : doff_q;
  assign idx_inc = {1'b0, idx} + CountW'(1);
  assign nidx    = (idx_inc == cnt) ? '0 : idx_inc[IdxW-1:0];
  assign emp_inc = emp_q + CountW'(1);

  // one planning step
  always_comb begin
    if (wr_q <= rp_q) run = (rp_q < end_q) ? end_q - rp_q : '0;
    else run = wr_q - rp_q;
    chunk_s = rem_q;
    if (run < {16'b0, chunk_s}) chunk_s = run[15:0];
    if ({8'b0, chunk_s} > pend_q) chunk_s = pend_q[15:0];
    fill_now = fill_q || (chunk_s == '0);
    chunk    = fill_now ? rem_q : chunk_s;
    size     = size_mem[idx];
    room     = (off < size) ? size - off : '0;
    room0    = (room == '0);
    seg      = (chunk < room) ? chunk : room;
    emp_hit  = (emp_inc >= cnt);
    rem_zero = (rem_q == '0);
    seg_lim  = (nseg_q >= SegCntW'(rsc_pkg::MaxSegs));
    finish   = rem_zero || seg_lim || (room0 && emp_hit);
    fin_trunc = !rem_zero && (seg_lim || (room0 && emp_hit));
    emit     = !rem_zero && !seg_lim && !room0;
    rsum     = rp_q + {16'b0, seg};
    rnext    = (rsum == end_q) ? base_q : rsum;
    dst      = dest_mem[idx] + {16'b0, off};
  end

  // query answer
  assign prod  = {5'b0, size} * {16'b0, cnt};
  assign avail = (pend_q >= {3'b0, prod}) ? {size, 1'b0} : {1'b0, size};

  assign psum = {1'b0, pend_q} + {{(PendW-15){1'b0}}, byte_count_i};

  assign cfg_we      = psel && penable && pwrite;
  assign out_pop     = out_valid_q && !out_stall_i;
  assign out_we_step = ctl_i.step && (finish || (emit && held_valid_q));

  assign sts_o.finish    = finish;
  assign sts_o.out_valid = out_valid_q;

  // register readback
  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      rsc_pkg::REG_ATTACHED:   prdata = {31'b0, attached_q};
      rsc_pkg::REG_SRC_BASE:   prdata = base_q;
      rsc_pkg::REG_SRC_END:    prdata = end_q;
      rsc_pkg::REG_SRC_START:  prdata = start_q;
      rsc_pkg::REG_ELEM_COUNT: prdata = {27'b0, ecount_q};
      default:                 prdata = '0;
    endcase
  end

  // element tables
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      dest_mem[elem_index_i] <= elem_dest_i;
      size_mem[elem_index_i] <= elem_size_i;
    end
  end

  // configuration and planner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q   <= 1'b0;
      base_q       <= '0;
      end_q        <= '0;
      start_q      <= '0;
      ecount_q     <= CountW'(1);
      rp_q         <= '0;
      pend_q       <= '0;
      didx_q       <= '0;
      doff_q       <= '0;
      live_q       <= 1'b0;
      rem_q        <= '0;
      wr_q         <= '0;
      fill_q       <= 1'b0;
      emp_q        <= '0;
      nseg_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (paddr[4:2])
          rsc_pkg::REG_ATTACHED: begin
            attached_q <= pwdata[0];
            live_q     <= pwdata[0];
            if (pwdata[0]) rp_q <= start_q;
          end
          rsc_pkg::REG_SRC_BASE:  base_q <= pwdata;
          rsc_pkg::REG_SRC_END:   end_q  <= pwdata;
          rsc_pkg::REG_SRC_START: begin
            start_q <= pwdata;
            rp_q    <= pwdata;
          end
          rsc_pkg::REG_ELEM_COUNT: begin
            ecount_q <= pwdata[CountW-1:0];
            if ({1'b0, didx_q} >= rsc_pkg::eff_count(pwdata[CountW-1:0])) begin
              didx_q <= '0;
              doff_q <= '0;
            end
          end
          default: ;
        endcase
      end
      if (ctl_i.produce) begin
        pend_q <= psum[PendW] ? {PendW{1'b1}} : psum[PendW-1:0];
      end
      if (ctl_i.free) begin
        live_q <= 1'b0;
        pend_q <= '0;
      end
      if (ctl_i.start_copy) begin
        rem_q  <= byte_count_i;
        wr_q   <= src_write_addr_i;
        fill_q <= !live_q;
        emp_q  <= '0;
        nseg_q <= '0;
      end
      if (ctl_i.query) begin
        didx_q <= idx;
        doff_q <= off;
      end
      if (ctl_i.step) begin
        if (finish) held_valid_q <= 1'b0;
        if (!rem_zero && !seg_lim) begin
          fill_q <= fill_now;
          if (room0) begin
            didx_q <= nidx;
            doff_q <= '0;
            emp_q  <= emp_inc;
          end else begin
            if (!fill_now) begin
              rp_q   <= rnext;
              pend_q <= pend_q - {8'b0, seg};
            end
            rem_q  <= rem_q - seg;
            emp_q  <= '0;
            nseg_q <= nseg_q + SegCntW'(1);
            held_valid_q <= 1'b1;
            if (seg == room) begin
              didx_q <= nidx;
              doff_q <= '0;
            end else begin
              didx_q <= idx;
              doff_q <= off + seg;
            end
          end
        end
      end
    end
  end

  // held segment payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.step && emit) begin
      h_src_q <= fill_now ? '0 : rp_q;
      h_zf_q  <= fill_now;
      h_dst_q <= dst;
      h_len_q <= seg;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.query || out_we_step) begin
      out_valid_q <= 1'b1;
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.query) begin
      seg_src_addr_o  <= '0;
      seg_zero_fill_o <= 1'b0;
      seg_dst_addr_o  <= '0;
      seg_len_o       <= '0;
      last_o          <= 1'b1;
      avail_bytes_o   <= avail;
      truncated_o     <= 1'b0;
    end else if (out_we_step) begin
      seg_src_addr_o  <= held_valid_q ? h_src_q : '0;
      seg_zero_fill_o <= held_valid_q ? h_zf_q : 1'b0;
      seg_dst_addr_o  <= held_valid_q ? h_dst_q : '0;
      seg_len_o       <= held_valid_q ? h_len_q : '0;
      last_o          <= finish;
      avail_bytes_o   <= '0;
      truncated_o     <= finish && fin_trunc;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_seg_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nseg_q <= SegCntW'(rsc_pkg::MaxSegs))
    else $error("segment count above limit");
  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (nseg_q != '0))
    else $error("held segment without count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(seg_len_o)))
    else $error("stalled result lost");
  a_step_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && out_valid_q) |-> !out_stall_i)
    else $error("step while output blocked");
`endif

endmodule

>>> design/ring_to_sg_copy_engine.sv
// Ring to scatter-gather copy planner. Load, produce and free requests
// complete in their accepting cycle; a size query is answered from a query
// state once the output register is free. A copy request runs as one
// planning step per emitted segment or skipped full element and one closing
// step that marks the final result (when every element is found full, the
// last skip is the closing step). Each step waits until the single output
// register is free; a segment is held one step so that last and truncated
// can be marked on it. At most 64 segments are emitted per copy. One request
// is in work at a time; a new one is taken while the final result of the
// previous one still waits in the output register.
module ring_to_sg_copy_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  elem_index_i,
  input  logic [31:0] elem_dest_i,
  input  logic [15:0] elem_size_i,
  input  logic [15:0] byte_count_i,
  input  logic [31:0] src_write_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] seg_src_addr_o,
  output logic        seg_zero_fill_o,
  output logic [31:0] seg_dst_addr_o,
  output logic [15:0] seg_len_o,
  output logic        last_o,
  output logic [16:0] avail_bytes_o,
  output logic        truncated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rsc_pkg::ctl_t ctl;
  rsc_pkg::sts_t sts;

  rsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rsc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .elem_index_i     (elem_index_i),
    .elem_dest_i      (elem_dest_i),
    .elem_size_i      (elem_size_i),
    .byte_count_i     (byte_count_i),
    .src_write_addr_i (src_write_addr_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .seg_src_addr_o   (seg_src_addr_o),
    .seg_zero_fill_o  (seg_zero_fill_o),
    .seg_dst_addr_o   (seg_dst_addr_o),
    .seg_len_o        (seg_len_o),
    .last_o           (last_o),
    .avail_bytes_o    (avail_bytes_o),
    .truncated_o      (truncated_o)
  );

endmodule

>>> tb/tb_ring_to_sg_copy_engine.sv
`timescale 1ns / 100ps

module tb_ring_to_sg_copy_engine;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 8;

  // One expected result of a request
  typedef struct packed {
    logic [31:0] src_addr;
    logic        zero_fill;
    logic [31:0] dst_addr;
    logic [15:0] len;
    logic        last;
    logic [16:0] avail;
    logic        truncated;
  } seg_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = rsc_pkg::CMD_LOAD;
  logic [3:0]  elem_index_i = '0;
  logic [31:0] elem_dest_i = '0;
  logic [15:0] elem_size_i = '0;
  logic [15:0] byte_count_i = '0;
  logic [31:0] src_write_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] seg_src_addr_o;
  logic        seg_zero_fill_o;
  logic [31:0] seg_dst_addr_o;
  logic [15:0] seg_len_o;
  logic        last_o;
  logic [16:0] avail_bytes_o;
  logic        truncated_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ring_to_sg_copy_engine i_dut (.*);

  // Predictor state
  logic [31:0] ring_base, ring_end, ring_start, rd_ptr;
  logic        attached, live;
  logic [4:0]  elem_cnt_reg;
  logic [31:0] dest_tab [16];
  logic [15:0] size_tab [16];
  logic [23:0] pend;
  logic [3:0]  cur_elem;
  logic [15:0] cur_off;

  seg_t expected_segs[$];
  int unsigned errors = 0, cycles = 0;
  int unsigned n_copies = 0, n_queries = 0, n_segs = 0, n_trunc = 0;
  bit quiet = 1'b0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned active_elems();
    int unsigned c;
    c = elem_cnt_reg;
    if (c < 1) c = 1;
    if (c > rsc_pkg::MaxElems) c = rsc_pkg::MaxElems;
    return c;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      rsc_pkg::REG_ATTACHED: begin
        attached = v[0];
        live = v[0];
        if (live) rd_ptr = ring_start;
      end
      rsc_pkg::REG_SRC_BASE: ring_base = v;
      rsc_pkg::REG_SRC_END: ring_end = v;
      rsc_pkg::REG_SRC_START: begin
        ring_start = v;
        rd_ptr = v;
      end
      rsc_pkg::REG_ELEM_COUNT: begin
        elem_cnt_reg = v[4:0];
        if (cur_elem >= active_elems()) begin
          cur_elem = '0;
          cur_off = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Plan a copy request into segments
  function automatic void plan_copy(input logic [15:0] nbytes, input logic [31:0] wr);
    int unsigned remaining, chunk, run, room, len, cnt, empties;
    logic [31:0] r;
    bit fill, trunc;
    seg_t s;
    seg_t batch[$];
    remaining = nbytes;
    cnt = active_elems();
    fill = !live;
    trunc = 1'b0;
    empties = 0;
    while (remaining > 0) begin
      chunk = 0;
      r = rd_ptr;
      if (batch.size() >= rsc_pkg::MaxSegs) begin
        trunc = 1'b1;
        break;
      end
      if (!fill) begin
        if (wr <= r) run = (r < ring_end) ? ring_end - r : 0;
        else run = wr - r;
        chunk = run;
        if (chunk > remaining) chunk = remaining;
        if (chunk > pend) chunk = pend;
        if (chunk == 0) fill = 1'b1;
      end
      if (fill) chunk = remaining;
      if (cur_elem >= cnt) begin
        cur_elem = '0;
        cur_off = '0;
      end
      room = (cur_off < size_tab[cur_elem]) ? size_tab[cur_elem] - cur_off : 0;
      if (room == 0) begin
        cur_elem = (cur_elem + 1) % cnt;
        cur_off = '0;
        empties++;
        if (empties >= cnt) begin
          trunc = 1'b1;
          break;
        end
        continue;
      end
      empties = 0;
      len = (chunk < room) ? chunk : room;
      s = '0;
      s.src_addr = fill ? 32'd0 : r;
      s.zero_fill = fill;
      s.dst_addr = dest_tab[cur_elem] + cur_off;
      s.len = len;
      batch.push_back(s);
      if (!fill) begin
        r = r + len;
        if (r == ring_end) r = ring_base;
        rd_ptr = r;
        pend = pend - len;
      end
      remaining -= len;
      if (len == room) begin
        cur_elem = (cur_elem + 1) % cnt;
        cur_off = '0;
      end else begin
        cur_off = cur_off + len;
      end
    end
    if (batch.size() == 0) batch.push_back('0);
    batch[$].last = 1'b1;
    batch[$].truncated = trunc;
    n_copies++;
    n_segs += batch.size();
    if (trunc) n_trunc++;
    foreach (batch[i]) expected_segs.push_back(batch[i]);
  endfunction

  // Catch-up size query
  function automatic void answer_query();
    int unsigned cnt, avail;
    seg_t s;
    cnt = active_elems();
    if (cur_elem >= cnt) begin
      cur_elem = '0;
      cur_off = '0;
    end
    avail = size_tab[cur_elem];
    if (pend >= avail * cnt) avail = avail * 2;
    s = '0;
    s.avail = avail;
    s.last = 1'b1;
    n_queries++;
    expected_segs.push_back(s);
  endfunction

  function automatic void predict_request(input logic [2:0] cmd, input logic [3:0] idx,
      input logic [31:0] dest, input logic [15:0] size, input logic [15:0] nbytes,
      input logic [31:0] wr);
    int unsigned p;
    case (cmd)
      rsc_pkg::CMD_LOAD: begin
        dest_tab[idx] = dest;
        size_tab[idx] = size;
      end
      rsc_pkg::CMD_PRODUCE: begin
        p = pend + nbytes;
        pend = (p > 24'hFFFFFF) ? 24'hFFFFFF : p;
      end
      rsc_pkg::CMD_COPY: plan_copy(nbytes, wr);
      rsc_pkg::CMD_FREE: begin
        live = 1'b0;
        pend = '0;
      end
      rsc_pkg::CMD_QUERY: answer_query();
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result checker and output stall
  always @(posedge clk_i) begin
    seg_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_segs.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = expected_segs.pop_front();
        check_field("seg_src_addr", e.src_addr, seg_src_addr_o);
        check_field("seg_zero_fill", e.zero_fill, seg_zero_fill_o);
        check_field("seg_dst_addr", e.dst_addr, seg_dst_addr_o);
        check_field("seg_len", e.len, seg_len_o);
        check_field("last", e.last, last_o);
        check_field("avail_bytes", e.avail, avail_bytes_o);
        check_field("truncated", e.truncated, truncated_o);
      end
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 17);
  end

  // Send one request; valid stays high afterwards
  task automatic send_req(input logic [2:0] cmd, input logic [3:0] idx,
      input logic [31:0] dest, input logic [15:0] size, input logic [15:0] nbytes,
      input logic [31:0] wr);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd_i <= cmd;
    elem_index_i <= idx;
    elem_dest_i <= dest;
    elem_size_i <= size;
    byte_count_i <= nbytes;
    src_write_addr_i <= wr;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(cmd, idx, dest, size, nbytes, wr);
  endtask

  task automatic load_elem(input logic [3:0] idx, input logic [31:0] dest,
      input logic [15:0] size);
    send_req(rsc_pkg::CMD_LOAD, idx, dest, size, 16'($urandom), $urandom);
  endtask

  task automatic produce(input logic [15:0] nbytes);
    send_req(rsc_pkg::CMD_PRODUCE, 4'($urandom), $urandom, 16'($urandom), nbytes,
             $urandom);
  endtask

  task automatic copy(input logic [15:0] nbytes, input logic [31:0] wr);
    send_req(rsc_pkg::CMD_COPY, 4'($urandom), $urandom, 16'($urandom), nbytes, wr);
  endtask

  task automatic plain(input logic [2:0] cmd);
    send_req(cmd, 4'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom);
  endtask

  // Drain all results, then let the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(idx, v);
  endtask

  task automatic set_ring(input logic [31:0] base, input logic [31:0] lim,
      input logic [31:0] start);
    write_reg(rsc_pkg::REG_SRC_BASE, base);
    write_reg(rsc_pkg::REG_SRC_END, lim);
    write_reg(rsc_pkg::REG_SRC_START, start);
    write_reg(rsc_pkg::REG_ATTACHED, 32'd1);
  endtask

  // Fill every element slot so no unwritten entry is ever read
  task automatic test_load_all();
    load_elem(4'd0, 32'hFFFF_FFF0, 16'hFFFF);
    load_elem(4'd15, 32'h0, 16'd1);
    for (int i = 1; i < 15; i++) load_elem(4'(i), $urandom, 16'($urandom_range(1, 48)));
    plain(rsc_pkg::CMD_QUERY);
  endtask

  task automatic test_source_copy();
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd31);
    set_ring(32'h0000_1000, 32'h0000_1080, 32'h0000_1070);
    produce(16'hFFFF);
    copy(16'd0, 32'h1000);
    copy(16'd40, rd_ptr);          // writer not ahead: runs to ring end, wraps
    copy(16'd30, rd_ptr + 32'd12); // writer ahead
    plain(rsc_pkg::CMD_QUERY);
    copy(16'hFFFF, 32'hFFFF_FFFF);
    for (logic [2:0] c = 3'd5; c != 3'd0; c++) plain(c);
  endtask

  task automatic test_zero_fill();
    settle();
    set_ring(32'hFFFF_FF00, 32'hFFFF_FF80, 32'hFFFF_FFC0); // start past end
    produce(16'd100);
    copy(16'd50, 32'hFFFF_FF00);
    plain(rsc_pkg::CMD_FREE);
    copy(16'd20, rd_ptr + 32'd8);
  endtask

  task automatic test_empty_element();
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd1);
    load_elem(4'd0, 32'h2000_0000, 16'd100);
    copy(16'd10, 32'h0);
    load_elem(4'd0, 32'h2000_0000, 16'd5);
    copy(16'd20, 32'h0);           // every element full: dropped
    load_elem(4'd0, 32'h2000_0000, 16'd100);
    copy(16'd10, 32'h0);
    load_elem(4'd0, 32'h2000_0000, 16'd5);
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd2);
    copy(16'd20, 32'h0);           // skips the full element
  endtask

  task automatic test_seg_limit();
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd16);
    for (int i = 0; i < 16; i++) load_elem(4'(i), $urandom, 16'($urandom_range(1, 3)));
    copy(16'd1000, 32'h0);
    copy(16'hFFFF, 32'h0);
  endtask

  task automatic test_count_shrink();
    copy(16'd7, 32'h0);
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd2);
    plain(rsc_pkg::CMD_QUERY);
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd0);
    plain(rsc_pkg::CMD_QUERY);
  endtask

  task automatic test_pending_saturation();
    settle();
    write_reg(rsc_pkg::REG_ELEM_COUNT, 32'd16);
    write_reg(rsc_pkg::REG_ATTACHED, 32'd1);
    quiet = 1'b1;
    repeat (258) produce(16'hFFFF);
    quiet = 1'b0;
    plain(rsc_pkg::CMD_QUERY);
    settle();
    write_reg(rsc_pkg::REG_ATTACHED, 32'd0);
    copy(16'd16, 32'h0);
    plain(rsc_pkg::CMD_FREE);
  endtask

  task automatic test_random();
    logic [31:0] base, wr;
    int unsigned pick;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(rsc_pkg::REG_ELEM_COUNT, (ph == 3) ? 32'd16 : $urandom_range(0, 31));
      base = $urandom;
      set_ring(base, base + $urandom_range(32, 600), base + $urandom_range(0, 620));
      for (int k = 0; k < 25; k++) begin
        quiet = (ph == 2) && (k > 2) && (k < 23);
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0) wr = rd_ptr;
        else if ($urandom_range(7) == 0) wr = $urandom;
        else wr = rd_ptr + $urandom_range(1, 300);
        if (pick < 10)
          load_elem(4'($urandom), $urandom,
                    16'(($urandom_range(15) == 0) ? 16'hFFFF : $urandom_range(1, 64)));
        else if (pick < 30)
          produce(16'(($urandom_range(15) == 0) ? 16'hFFFF : $urandom_range(0, 200)));
        else if (pick < 77)
          copy(16'(($urandom_range(19) == 0) ? 16'hFFFF : $urandom_range(0, 150)), wr);
        else if (pick < 80)
          plain(rsc_pkg::CMD_FREE);
        else if (pick < 94)
          plain(rsc_pkg::CMD_QUERY);
        else
          plain(3'($urandom_range(5, 7)));
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    ring_base = '0; ring_end = '0; ring_start = '0; rd_ptr = '0;
    attached = 1'b0; live = 1'b0; elem_cnt_reg = 5'd1;
    pend = '0; cur_elem = '0; cur_off = '0;
    foreach (dest_tab[i]) begin
      dest_tab[i] = '0;
      size_tab[i] = '0;
    end
    test_load_all();
    test_source_copy();
    test_zero_fill();
    test_empty_element();
    test_seg_limit();
    test_count_shrink();
    test_pending_saturation();
    test_random();
    settle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d copies (%0d segments, %0d cut short) and %0d size queries",
             n_copies, n_segs, n_trunc, n_queries);
    $display("over ring wrap, zero fill, full elements and pending saturation");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
